FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, switched off while reset is high.
`define SED_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication into the next cycle, switched off while reset is high.
`define SED_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication into the next cycle that also holds across reset.
`define SED_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

   typedef struct packed {
      logic a_neg;
      logic d_neg;
      logic dz;
   } sed_flags_type;

endpackage

FILE: hw/rtl/sed_req_if.sv
`timescale 1ns / 1ps

interface sed_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] dividend;
   logic signed [DATA_WIDTH-1:0] divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink (input valid, input dividend, input divisor, output ready);
endinterface

FILE: hw/rtl/sed_rsp_if.sv
`timescale 1ns / 1ps

interface sed_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] quotient;
   logic        [DATA_WIDTH-2:0] remainder;
   logic                         div_by_zero;
   logic                         overflow;

   modport source (output valid, output quotient, output remainder, output div_by_zero,
                   output overflow, input ready);
   modport sink (input valid, input quotient, input remainder, input div_by_zero,
                 input overflow, output ready);
endinterface

FILE: hw/rtl/signed_euclidean_divider.sv
`timescale 1ns / 1ps

// Signed Euclidean divider.
// A transaction on req_chan carries a signed dividend and divisor. Each one yields
// exactly one transaction on rsp_chan with the Euclidean quotient, a remainder that
// is never negative and below the divisor magnitude, and the flags div_by_zero and
// overflow. A zero divisor gives zero results with div_by_zero set; the minimum
// dividend over minus one saturates the quotient and sets overflow.
// On the way to rsp_chan.valid, the accepting edge loads the operand magnitudes, a row
// of DATA_WIDTH cells settles one quotient bit each, and the sign fix-up is applied
// into the output register. The row moves as a whole, so a new transaction may be
// accepted in every cycle while it moves, that is, while no result waits on a
// stalled receiver.
// When the receiver stalls with a result waiting, the whole row and req_chan.ready
// hold until that result is taken. Synchronous reset empties the row and the
// output register; no result is lost or repeated across a stall.
module signed_euclidean_divider #(
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   sed_req_if.sink   req_chan,
   sed_rsp_if.source rsp_chan
);
   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic advance;

   logic                   valid_w [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  rem_w   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  aq_w    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0]  dm_w    [0:DATA_WIDTH];
   sed_pkg::sed_flags_type flags_w [0:DATA_WIDTH];

   logic                   front_valid_ff;
   logic [DATA_WIDTH-1:0]  front_am_ff;
   logic [DATA_WIDTH-1:0]  front_dm_ff;
   sed_pkg::sed_flags_type front_flags_ff;
   logic [DATA_WIDTH-1:0]  front_am_in;
   logic [DATA_WIDTH-1:0]  front_dm_in;
   sed_pkg::sed_flags_type front_flags_in;

   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] quotient_ff;
   logic [DATA_WIDTH-2:0] remainder_ff;
   logic                  div_by_zero_ff;
   logic                  overflow_ff;
   logic [DATA_WIDTH-1:0] quotient_in;
   logic [DATA_WIDTH-1:0] rem_full;
   logic                  overflow_in;

   logic [DATA_WIDTH-1:0] q0;
   logic [DATA_WIDTH-1:0] r0;
   logic [DATA_WIDTH-1:0] dm_last;
   sed_pkg::sed_flags_type flags_last;
   logic                  q_neg;
   logic                  r_nz;

   assign advance        = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = advance;

   always_comb begin
      front_flags_in.a_neg = req_chan.dividend[DATA_WIDTH-1];
      front_flags_in.d_neg = req_chan.divisor[DATA_WIDTH-1];
      front_flags_in.dz    = (req_chan.divisor == '0);
      front_am_in = front_flags_in.a_neg ? (DATA_WIDTH'(0) - req_chan.dividend)
                                         : req_chan.dividend;
      front_dm_in = front_flags_in.d_neg ? (DATA_WIDTH'(0) - req_chan.divisor)
                                         : req_chan.divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_am_ff    <= front_am_in;
         front_dm_ff    <= front_dm_in;
         front_flags_ff <= front_flags_in;
      end
   end

   assign valid_w[0] = front_valid_ff;
   assign rem_w[0]   = '0;
   assign aq_w[0]    = front_am_ff;
   assign dm_w[0]    = front_dm_ff;
   assign flags_w[0] = front_flags_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sed_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_prev(valid_w[i]),
         .rem_prev  (rem_w[i]),
         .aq_prev   (aq_w[i]),
         .dm_prev   (dm_w[i]),
         .flags_prev(flags_w[i]),
         .valid_ff  (valid_w[i+1]),
         .rem_ff    (rem_w[i+1]),
         .aq_ff     (aq_w[i+1]),
         .dm_ff     (dm_w[i+1]),
         .flags_ff  (flags_w[i+1])
      );
   end

   always_comb begin
      q0          = aq_w[DATA_WIDTH];
      r0          = rem_w[DATA_WIDTH];
      dm_last     = dm_w[DATA_WIDTH];
      flags_last  = flags_w[DATA_WIDTH];
      q_neg       = flags_last.a_neg ^ flags_last.d_neg;
      r_nz        = (r0 != '0);
      quotient_in = '0;
      rem_full    = '0;
      overflow_in = 1'b0;
      if (flags_last.dz) begin
         quotient_in = '0;
      end else if (flags_last.a_neg && r_nz) begin
         quotient_in = q_neg ? ~q0 : (q0 + DATA_WIDTH'(1));
         rem_full    = dm_last - r0;
      end else begin
         rem_full = r0;
         if (q_neg) begin
            quotient_in = DATA_WIDTH'(0) - q0;
         end else if (q0[DATA_WIDTH-1]) begin
            quotient_in = MaxPos;
            overflow_in = 1'b1;
         end else begin
            quotient_in = q0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_w[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff    <= quotient_in;
         remainder_ff   <= rem_full[DATA_WIDTH-2:0];
         div_by_zero_ff <= flags_last.dz;
         overflow_ff    <= overflow_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.quotient    = quotient_ff;
   assign rsp_chan.remainder   = remainder_ff;
   assign rsp_chan.div_by_zero = div_by_zero_ff;
   assign rsp_chan.overflow    = overflow_ff;
endmodule

FILE: hw/rtl/sed_cell.sv
`timescale 1ns / 1ps

// One restoring step: shift in the next dividend bit, trial subtract, keep a quotient bit.
module sed_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_prev,
   input  logic [DATA_WIDTH-1:0] rem_prev,
   input  logic [DATA_WIDTH-1:0] aq_prev,
   input  logic [DATA_WIDTH-1:0] dm_prev,
   input  sed_pkg::sed_flags_type flags_prev,
   output logic                  valid_ff,
   output logic [DATA_WIDTH-1:0] rem_ff,
   output logic [DATA_WIDTH-1:0] aq_ff,
   output logic [DATA_WIDTH-1:0] dm_ff,
   output sed_pkg::sed_flags_type flags_ff
);
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  qbit;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [DATA_WIDTH-1:0] aq_in;

   always_comb begin
      shifted = {rem_prev[DATA_WIDTH-2:0], aq_prev[DATA_WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, dm_prev};
      qbit    = ~diff[DATA_WIDTH];
      rem_in  = qbit ? diff[DATA_WIDTH-1:0] : shifted;
      aq_in   = {aq_prev[DATA_WIDTH-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff   <= rem_in;
         aq_ff    <= aq_in;
         dm_ff    <= dm_prev;
         flags_ff <= flags_prev;
      end
   end
endmodule

FILE: hw/rtl/sed_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sed_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_quotient,
   input logic [DATA_WIDTH-2:0] rsp_remainder,
   input logic                  rsp_div_by_zero,
   input logic                  rsp_overflow
);
   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic dz_clean;
   logic ovf_clean;

   assign dz_clean  = (rsp_quotient == '0) && (rsp_remainder == '0) && !rsp_overflow;
   assign ovf_clean = (rsp_quotient == MaxPos) && (rsp_remainder == '0) && !rsp_div_by_zero;

   `SED_ASSERT_ALWAYS(a_reset_empties, reset, !rsp_valid)
   `SED_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid)
   `SED_ASSERT_NOW(a_dz_zero, rsp_valid && rsp_div_by_zero, dz_clean)
   `SED_ASSERT_NOW(a_ovf_sat, rsp_valid && rsp_overflow, ovf_clean)
endmodule

bind signed_euclidean_divider sed_checker #(
   .DATA_WIDTH(DATA_WIDTH)
) u_sed_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_quotient   (rsp_chan.quotient),
   .rsp_remainder  (rsp_chan.remainder),
   .rsp_div_by_zero(rsp_chan.div_by_zero),
   .rsp_overflow   (rsp_chan.overflow)
);

FILE: bench/tb_signed_euclidean_divider.sv
`timescale 1ns / 1ps

module tb_signed_euclidean_divider;

   localparam int DW = 32;
   localparam int PHASE_ITEMS = 460;
   localparam int LIMIT_CYCLES = 200000;
   localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

   typedef struct packed {
      logic signed [DW-1:0] quotient;
      logic        [DW-2:0] remainder;
      logic                 div_by_zero;
      logic                 overflow;
   } div_result_type;

   typedef struct packed {
      logic signed [DW-1:0] dividend;
      logic signed [DW-1:0] divisor;
      logic                 typed;
      div_result_type       want;
   } stim_row_type;

   typedef struct packed {
      logic signed [DW-1:0] dividend;
      logic signed [DW-1:0] divisor;
      div_result_type       want;
   } division_type;

   logic clock;
   logic reset;

   sed_req_if #(.DATA_WIDTH(DW)) req_chan ();
   sed_rsp_if #(.DATA_WIDTH(DW)) rsp_chan ();

   signed_euclidean_divider #(.DATA_WIDTH(DW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   division_type divisions_due[$];
   division_type offered_division;
   stim_row_type directed_rows[24];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 26;
   int           recv_idle_pct = 81;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic div_result_type euclid_divide(input logic signed [DW-1:0] num,
                                                    input logic signed [DW-1:0] den);
      longint         num_mag;
      longint         den_mag;
      longint         quo_mag;
      longint         rem_mag;
      div_result_type res;
      res = '0;
      num_mag = num[DW-1] ? -longint'(num) : longint'(num);
      den_mag = den[DW-1] ? -longint'(den) : longint'(den);
      if (den_mag == 0) begin
         res.div_by_zero = 1'b1;
      end else begin
         quo_mag = num_mag / den_mag;
         rem_mag = num_mag % den_mag;
         if (num[DW-1] && rem_mag != 0) begin
            quo_mag = quo_mag + 1;
            rem_mag = den_mag - rem_mag;
         end
         if (num[DW-1] ^ den[DW-1]) begin
            res.quotient = DW'(-quo_mag);
         end else if (quo_mag > longint'(MAX_VAL)) begin
            res.quotient = MAX_VAL;
            res.overflow = 1'b1;
         end else begin
            res.quotient = DW'(quo_mag);
         end
         res.remainder = (DW-1)'(rem_mag);
      end
      return res;
   endfunction

   function automatic logic signed [DW-1:0] pick_operand();
      logic signed [DW-1:0] val;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 6))
               0: val = '0;
               1: val = 1;
               2: val = -1;
               3: val = MIN_VAL;
               4: val = MAX_VAL;
               5: val = MIN_VAL + 1;
               default: val = MAX_VAL - 1;
            endcase
         end
         1, 2: val = $urandom_range(0, 64) - 32;
         3, 4: begin
            val = $urandom >> $urandom_range(0, 30);
            if ($urandom_range(0, 1) == 1) val = -val;
         end
         default: val = $urandom;
      endcase
      return val;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want,
                                  input division_type div);
      if (error_count < 40) begin
         $display("[%0t] mismatch on %s: got %0d, expected %0d (dividend %0d, divisor %0d)",
                  $time, what, got, want, div.dividend, div.divisor);
      end
      error_count = error_count + 1;
   endtask

   task automatic send_item(input logic signed [DW-1:0] num, input logic signed [DW-1:0] den,
                            input div_result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.dividend <= num;
      req_chan.divisor <= den;
      offered_division = '{dividend: num, divisor: den, want: want};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (divisions_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic signed [DW-1:0] num;
      logic signed [DW-1:0] den;
      int                   factor;
      repeat (count) begin
         den = pick_operand();
         if ($urandom_range(0, 4) == 0) begin
            factor = $urandom_range(0, 40);
            factor = factor - 20;
            num = den * factor;
         end else begin
            num = pick_operand();
         end
         send_item(num, den, euclid_divide(num, den));
      end
   endtask

   always @(posedge clock) begin
      division_type div;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) divisions_due.push_back(offered_division);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (divisions_due.size() == 0) begin
               report_mismatch("result with no transaction outstanding", rsp_chan.quotient, 0,
                               '0);
            end else begin
               div = divisions_due.pop_front();
               if (rsp_chan.quotient !== div.want.quotient)
                  report_mismatch("quotient", rsp_chan.quotient, div.want.quotient, div);
               if (rsp_chan.remainder !== div.want.remainder)
                  report_mismatch("remainder", rsp_chan.remainder, div.want.remainder, div);
               if (rsp_chan.div_by_zero !== div.want.div_by_zero)
                  report_mismatch("div_by_zero", rsp_chan.div_by_zero, div.want.div_by_zero,
                                  div);
               if (rsp_chan.overflow !== div.want.overflow)
                  report_mismatch("overflow", rsp_chan.overflow, div.want.overflow, div);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      stim_row_type row;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.dividend = '0;
      req_chan.divisor = '0;
      offered_division = '0;
      directed_rows = '{
         '{32'sd7, 32'sd2, 1'b0, '0},
         '{-32'sd7, 32'sd2, 1'b0, '0},
         '{32'sd7, -32'sd2, 1'b0, '0},
         '{-32'sd7, -32'sd2, 1'b0, '0},
         '{-32'sd6, 32'sd3, 1'b1, '{-32'sd2, 31'd0, 1'b0, 1'b0}},
         '{-32'sd6, -32'sd3, 1'b1, '{32'sd2, 31'd0, 1'b0, 1'b0}},
         '{32'sd0, 32'sd5, 1'b1, '{32'sd0, 31'd0, 1'b0, 1'b0}},
         '{32'sd0, 32'sd0, 1'b1, '{32'sd0, 31'd0, 1'b1, 1'b0}},
         '{32'sd123, 32'sd0, 1'b1, '{32'sd0, 31'd0, 1'b1, 1'b0}},
         '{MIN_VAL, 32'sd0, 1'b1, '{32'sd0, 31'd0, 1'b1, 1'b0}},
         '{MIN_VAL, -32'sd1, 1'b1, '{MAX_VAL, 31'd0, 1'b0, 1'b1}},
         '{MIN_VAL, 32'sd1, 1'b1, '{MIN_VAL, 31'd0, 1'b0, 1'b0}},
         '{MAX_VAL, 32'sd1, 1'b1, '{MAX_VAL, 31'd0, 1'b0, 1'b0}},
         '{MAX_VAL, -32'sd1, 1'b1, '{MIN_VAL + 1, 31'd0, 1'b0, 1'b0}},
         '{MIN_VAL, MIN_VAL, 1'b1, '{32'sd1, 31'd0, 1'b0, 1'b0}},
         '{MAX_VAL, MIN_VAL, 1'b0, '0},
         '{MIN_VAL, MAX_VAL, 1'b0, '0},
         '{-32'sd1, MAX_VAL, 1'b0, '0},
         '{-32'sd1, MIN_VAL, 1'b0, '0},
         '{MAX_VAL, MAX_VAL, 1'b0, '0},
         '{-32'sd1, -32'sd1, 1'b0, '0},
         '{32'sd1, MIN_VAL, 1'b0, '0},
         '{MIN_VAL, 32'sd2, 1'b0, '0},
         '{MIN_VAL, -32'sd2, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.dividend, row.divisor,
                   row.typed ? row.want : euclid_divide(row.dividend, row.divisor));
      end
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 81 : 0;
         recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 26 : 0;
         send_random(PHASE_ITEMS);
         drain_results();
      end

      repeat (DW + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
